/* rtl/core/cnpc_pkg.sv */
// ----------------------------------------------------------------------------
// cnpc_pkg
// Shared constants and codes for the cross-neighbour peak clip filter.
// ----------------------------------------------------------------------------
package cnpc_pkg;

  // configuration register width and row index width
  localparam int CFG_BITS     = 11;
  localparam int ROW_BITS     = 10;
  localparam int CFG_IDX_BITS = 2;

  // largest frame height honored; larger values clamp to it
  localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT = 11'd1024;
  localparam logic [CFG_BITS-1:0] CFG_RESET    = 11'd1024;

  typedef logic [CFG_IDX_BITS-1:0] cfg_index_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

/* rtl/core/cross_neighbour_peak_clip.sv */
// ----------------------------------------------------------------------------
// cross_neighbour_peak_clip
// Four-neighbour peak clip filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Each output pixel is min(pixel, max(up, down, left, right)); neighbours
// outside the frame count as 0. Pixels arrive in raster order; input (r,c)
// releases output (r-1,c), so row 0 gives no output, and after the frame's
// rows one flush row of frame_width items (values ignored) releases the last
// row, flagged by frame_done on its final pixel. The block takes one pixel
// per clock while in_stall is low: the two line stores are one-read
// one-write synchronous RAMs read one column ahead, so the read-modify-write
// of column c overlaps the read of column c+1. A result is registered in
// stage B, then written into a three-entry output queue that absorbs
// downstream stall; in_stall rises only when that queue and the compute
// stage hold three results. Writing either configuration register restarts
// the frame (counters and window cleared, line store contents kept); write
// only while idle. No clearing pass after reset is needed: the first row of
// a frame never uses what it reads from the stores.
// ----------------------------------------------------------------------------
module cross_neighbour_peak_clip #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  cnpc_pkg::cfg_index_t            cfg_index,
  input  logic [cnpc_pkg::CFG_BITS-1:0]   cfg_data,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PIXEL_BITS-1:0]           pixel_in,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [PIXEL_BITS-1:0]           pixel_out,
  output logic [cnpc_pkg::ROW_BITS-1:0]   out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]    out_col,
  output logic                            frame_done
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CB   = cnpc_pkg::CFG_BITS;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int EW   = (WW > CB) ? WW : CB;
  localparam int QD   = 3;   // output queue depth
  localparam int QPW  = 2;

  // ---------------------------------------------------------------- config
  logic [CB-1:0] frame_width;
  logic [CB-1:0] frame_height;
  logic          cfg_wr;
  logic          cfg_restart;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  // only the listed registers restart the frame
  assign cfg_restart = cfg_wr &&
                       (cfg_index inside {cnpc_pkg::REG_FRAME_WIDTH,
                                          cnpc_pkg::REG_FRAME_HEIGHT});

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cnpc_pkg::CFG_RESET;
      frame_height <= cnpc_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == cnpc_pkg::REG_FRAME_WIDTH) frame_width <= cfg_data;
      if (cfg_index == cnpc_pkg::REG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  // effective last column and height after clamping
  logic [EW-1:0] fw_ext;
  logic [AW-1:0] last_col;
  logic [CB-1:0] eff_h;

  assign fw_ext = EW'(frame_width);

  always_comb begin
    if (fw_ext == '0) last_col = '0;
    else if (fw_ext > EW'(MAX_WIDTH)) last_col = AW'(MAX_WIDTH - 1);
    else last_col = AW'(fw_ext - EW'(1));
  end

  always_comb begin
    if (frame_height == '0) eff_h = CB'(1);
    else if (frame_height > cnpc_pkg::HEIGHT_LIMIT) eff_h = cnpc_pkg::HEIGHT_LIMIT;
    else eff_h = frame_height;
  end

  // ---------------------------------------------------------------- stage A
  logic [AW-1:0]         col;
  logic [CB-1:0]         row;
  logic [AW-1:0]         c_eff;
  logic [CB-1:0]         r_eff;
  logic                  in_xfer;
  logic                  is_last;
  logic                  in_flush;
  logic                  has_result;
  logic                  line_wr;
  logic [AW-1:0]         rd_addr;
  logic [PIXEL_BITS-1:0] px;
  logic [PIXEL_BITS-1:0] left_of_centre;
  logic [PIXEL_BITS-1:0] cur_mid;

  assign in_xfer    = in_valid && !in_stall;
  assign c_eff      = (col > last_col) ? '0 : col;
  assign r_eff      = (row > eff_h) ? '0 : row;
  assign is_last    = (c_eff == last_col);
  assign in_flush   = (r_eff == eff_h);
  assign has_result = (r_eff != '0);
  assign line_wr    = in_xfer && !in_flush;
  assign px         = in_flush ? '0 : pixel_in;
  // read one column ahead; at row end fetch column 0 for the next row
  assign rd_addr    = is_last ? '0 : c_eff + AW'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      col            <= '0;
      row            <= '0;
      left_of_centre <= '0;
    end else if (in_xfer) begin
      if (is_last) begin
        col <= '0;
        row <= in_flush ? '0 : r_eff + CB'(1);
      end else begin
        col <= c_eff + AW'(1);
        row <= r_eff;
      end
      if (has_result) left_of_centre <= cur_mid;
    end
  end

  // ---------------------------------------------------------------- line stores
  logic [PIXEL_BITS-1:0] upper_line  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mid_q;
  logic [PIXEL_BITS-1:0] up_q;
  logic [PIXEL_BITS-1:0] fwd_mid;
  logic [PIXEL_BITS-1:0] fwd_up;
  logic                  fwd_sel;
  logic [PIXEL_BITS-1:0] cur_up;

  always_ff @(posedge clk) begin
    if (line_wr) begin
      upper_line[c_eff]  <= cur_mid;
      middle_line[c_eff] <= px;
    end
    if (in_xfer) begin
      mid_q <= middle_line[rd_addr];
      up_q  <= upper_line[rd_addr];
    end
  end

  // single-column frames read the entry written in the same transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_sel <= 1'b0;
    end else if (in_xfer) begin
      fwd_sel <= line_wr && (rd_addr == c_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_mid <= px;
      fwd_up  <= cur_mid;
    end
  end

  assign cur_mid = fwd_sel ? fwd_mid : mid_q;
  assign cur_up  = fwd_sel ? fwd_up  : up_q;

  // ---------------------------------------------------------------- stage B
  logic                           b_valid;
  logic [PIXEL_BITS-1:0]          b_centre;
  logic [PIXEL_BITS-1:0]          b_up;
  logic [PIXEL_BITS-1:0]          b_down;
  logic [PIXEL_BITS-1:0]          b_left;
  logic                           b_right_en;
  logic [cnpc_pkg::ROW_BITS-1:0]  b_row;
  logic [AW-1:0]                  b_col;
  logic                           b_done;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else b_valid <= in_xfer && has_result;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_centre   <= cur_mid;
      b_up       <= (r_eff >= CB'(2)) ? cur_up : '0;
      b_down     <= px;
      b_left     <= (c_eff != '0) ? left_of_centre : '0;
      b_right_en <= !is_last;
      b_row      <= cnpc_pkg::ROW_BITS'(r_eff - CB'(1));
      b_col      <= c_eff;
      b_done     <= in_flush && is_last;
    end
  end

  // right neighbour is the look-ahead read issued by this item
  logic [PIXEL_BITS-1:0] b_right;
  logic [PIXEL_BITS-1:0] max_ud;
  logic [PIXEL_BITS-1:0] max_lr;
  logic [PIXEL_BITS-1:0] peak;
  logic [PIXEL_BITS-1:0] clipped;

  assign b_right = b_right_en ? cur_mid : '0;
  assign max_ud  = (b_up > b_down) ? b_up : b_down;
  assign max_lr  = (b_left > b_right) ? b_left : b_right;
  assign peak    = (max_ud > max_lr) ? max_ud : max_lr;
  assign clipped = (b_centre < peak) ? b_centre : peak;

  // ---------------------------------------------------------------- output queue
  logic [PIXEL_BITS-1:0]         q_pix  [QD];
  logic [cnpc_pkg::ROW_BITS-1:0] q_row  [QD];
  logic [AW-1:0]                 q_col  [QD];
  logic                          q_done [QD];
  logic [QPW-1:0]                head;
  logic [QPW-1:0]                tail;
  logic [QPW-1:0]                count;
  logic                          pop;

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (b_valid) tail <= (tail == QPW'(QD - 1)) ? '0 : tail + QPW'(1);
      if (pop) head <= (head == QPW'(QD - 1)) ? '0 : head + QPW'(1);
      count <= count + QPW'(b_valid) - QPW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      q_pix[tail]  <= clipped;
      q_row[tail]  <= b_row;
      q_col[tail]  <= b_col;
      q_done[tail] <= b_done;
    end
  end

  // stall from registered occupancy only
  assign in_stall   = ({1'b0, count} + {{QPW{1'b0}}, b_valid}) >= (QPW + 1)'(QD);
  assign out_valid  = (count != '0);
  assign pixel_out  = q_pix[head];
  assign out_row    = q_row[head];
  assign out_col    = q_col[head];
  assign frame_done = q_done[head];

`ifndef SYNTHESIS
  // compute stage never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (count != QPW'(QD) || pop))
    else $error("output queue overflow");

  // an input with a result reaches the compute stage next cycle
  a_stage_b: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && has_result && !cfg_wr) |=> b_valid)
    else $error("result lost between stages");

  // frame end is only flagged on the last column
  a_done_col: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_done) |-> (b_col == last_col))
    else $error("frame_done off the last column");
`endif

endmodule

/* tb/peak_clip_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peak_clip_checker
// Watches the config, pixel and result channels of the peak clip filter,
// keeps its own copy of the line stores and counters, predicts each clipped
// pixel and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module peak_clip_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  cnpc_pkg::cfg_index_t            cfg_index,
  input  logic [cnpc_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [PIXEL_BITS-1:0]           pixel_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [PIXEL_BITS-1:0]           pixel_out,
  input  logic [cnpc_pkg::ROW_BITS-1:0]   out_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]    out_col,
  input  logic                            frame_done,
  output int                              fail_count,
  output int                              pending,
  output int                              checked_count,
  output int                              frame_count
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [PIXEL_BITS-1:0]         pix;
    logic [cnpc_pkg::ROW_BITS-1:0] row;
    logic [COL_BITS-1:0]           col;
    logic                          last;
  } clipped_px_t;

  clipped_px_t clipped_q[$];

  // predictor state: previous row, current row, west neighbour, position
  logic [PIXEL_BITS-1:0]         above_line  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]         centre_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]         west_px;
  int unsigned                   row_pos;
  int unsigned                   col_pos;
  logic [cnpc_pkg::CFG_BITS-1:0] width_reg;
  logic [cnpc_pkg::CFG_BITS-1:0] height_reg;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > cnpc_pkg::HEIGHT_LIMIT) return cnpc_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    west_px = '0;
    row_pos = 0;
    col_pos = 0;
  endfunction

  // one accepted pixel: emit (r-1,c) once row r >= 1, then update stores
  task automatic clip_pixel(input logic [PIXEL_BITS-1:0] pix_in);
    int unsigned           w, h, r, c;
    logic [PIXEL_BITS-1:0] px, mid, up, left, right, peak;
    clipped_px_t           res;
    w  = active_width();
    h  = active_height();
    r  = row_pos;
    c  = col_pos;
    px = pix_in;
    if (c >= w) c = 0;
    if (r > h) r = 0;
    if (r == h) px = '0;   // flush row: value ignored
    if (r >= 1) begin
      mid   = centre_line[c];
      up    = (r >= 2) ? above_line[c] : '0;
      left  = (c > 0) ? west_px : '0;
      right = (c + 1 < w) ? centre_line[c + 1] : '0;
      peak  = (up > px) ? up : px;
      if (left > peak) peak = left;
      if (right > peak) peak = right;
      res.pix  = (mid < peak) ? mid : peak;
      res.row  = cnpc_pkg::ROW_BITS'(r - 1);
      res.col  = COL_BITS'(c);
      res.last = (r == h) && (c + 1 == w);
      west_px  = mid;
      clipped_q = {clipped_q, res};
    end
    if (r < h) begin
      above_line[c]  = centre_line[c];
      centre_line[c] = px;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r > h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    clipped_px_t want;
    if (rst) begin
      width_reg  = cnpc_pkg::CFG_RESET;
      height_reg = cnpc_pkg::CFG_RESET;
      restart_frame();
      clipped_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (clipped_q.size() == 0) begin
          $error("unexpected result: pixel_out %0d out_row %0d out_col %0d frame_done %0d",
                 pixel_out, out_row, out_col, frame_done);
          fail_count++;
        end else begin
          want = clipped_q.pop_front();
          compare_field("pixel_out", want.pix, pixel_out);
          compare_field("out_row", want.row, out_row);
          compare_field("out_col", want.col, out_col);
          compare_field("frame_done", want.last, frame_done);
          checked_count++;
          if (frame_done) frame_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cnpc_pkg::REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
            restart_frame();
          end
          cnpc_pkg::REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) clip_pixel(pixel_in);
    end
    pending = clipped_q.size();
  end

endmodule

/* tb/tb_cross_neighbour_peak_clip.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cross_neighbour_peak_clip
// Drives raster frames into the peak clip filter under several frame sizes,
// random idling on both sides and back-to-back frames; the checker beside the
// block predicts every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_cross_neighbour_peak_clip;

  localparam int MAX_WIDTH     = 1024;
  localparam int PIXEL_BITS    = 16;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int CFG_BITS      = cnpc_pkg::CFG_BITS;
  // stop the random part after roughly this many small-frame pixels
  localparam int RANDOM_ITEMS  = 650;
  // pixels sent into each extreme-size frame before it is abandoned
  localparam int BIG_RUN       = 32;
  // cycles with no transfer on any channel before the run is declared hung;
  // a correct run never idles more than the settle gap plus a few stalls
  localparam int QUIET_LIMIT   = 4000;
  // result passes stage B before the output queue; margin for that queue
  localparam int SETTLE_CYCLES = 12;
  // register indexes with no register behind them
  localparam cnpc_pkg::cfg_index_t FIRST_UNMAPPED_REG = 2'd2;
  localparam cnpc_pkg::cfg_index_t LAST_UNMAPPED_REG  = 2'd3;

  // pixel content styles for random frames
  typedef enum int {TEX_TIES, TEX_BINARY, TEX_BRIGHT, TEX_NOISE} texture_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  cnpc_pkg::cfg_index_t          cfg_index;
  logic [CFG_BITS-1:0]           cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [PIXEL_BITS-1:0]         pixel_in;
  logic                          out_valid;
  logic                          out_stall;
  logic [PIXEL_BITS-1:0]         pixel_out;
  logic [cnpc_pkg::ROW_BITS-1:0] out_row;
  logic [COL_BITS-1:0]           out_col;
  logic                          frame_done;

  int fail_count, pending, checked_count, frame_count;
  int send_idle_pct, recv_idle_pct;
  int pixels_sent, quiet_cycles;

  always #1 clk = ~clk;

  cross_neighbour_peak_clip #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .out_row   (out_row),
    .out_col   (out_col),
    .frame_done(frame_done)
  );

  peak_clip_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_in     (pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_done   (frame_done),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count),
    .frame_count  (frame_count)
  );

  // Downstream back-pressure: fresh coin every falling edge, so stalls land
  // on every phase of the pipeline and the output queue.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hang detector: any transfer on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One pixel transfer. Called at a falling edge, returns at the falling edge
  // after the transfer. in_valid is left high so back-to-back pixels never
  // drop and re-raise it in one step; settle() lowers it.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Register write; cfg_valid stays high across consecutive writes.
  task automatic write_reg(input cnpc_pkg::cfg_index_t idx,
                           input logic [CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Both writes restart the frame. The optional write to an unused index
  // follows them, so it must leave the freshly restarted frame alone.
  task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                           input bit poke_unmapped);
    write_reg(cnpc_pkg::REG_FRAME_WIDTH, w);
    write_reg(cnpc_pkg::REG_FRAME_HEIGHT, h);
    if (poke_unmapped) begin
      write_reg(cnpc_pkg::cfg_index_t'($urandom_range(FIRST_UNMAPPED_REG,
                                                      LAST_UNMAPPED_REG)),
                CFG_BITS'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Drain: stop sending, wait for every predicted result, then give row-0
  // pixels (which produce nothing) time to leave the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [PIXEL_BITS-1:0] pick_pixel(input texture_t tex);
    case (tex)
      TEX_TIES:   return PIXEL_BITS'($urandom_range(0, 7));      // plateaus, equal peaks
      TEX_BINARY: return $urandom_range(0, 1) ? '1 : '0;
      TEX_BRIGHT: return PIXEL_BITS'($urandom_range(65520, 65535));
      default:    return PIXEL_BITS'($urandom);
    endcase
  endfunction

  task automatic send_run(input int unsigned count, input texture_t tex);
    repeat (count) send_pixel(pick_pixel(tex));
  endtask

  // pixels in one frame including its flush row, with register clamping
  function automatic int unsigned frame_items(input int unsigned w, input int unsigned h);
    int unsigned ew, eh;
    ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    eh = (h == 0) ? 1 : (h > cnpc_pkg::HEIGHT_LIMIT) ? cnpc_pkg::HEIGHT_LIMIT : h;
    return ew * (eh + 1);
  endfunction

  initial begin
    logic [PIXEL_BITS-1:0] seq [$];
    int unsigned           wr, hr, n_items, random_items, big_done, settings;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = cnpc_pkg::REG_FRAME_WIDTH;
    cfg_data      = '0;
    in_valid      = 1'b0;
    pixel_in      = '0;
    out_stall     = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 52;
    random_items  = 0;
    big_done      = 0;
    settings      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---------------------------------------------------------
    // single pixel frame: no neighbours, so output is 0 even for full scale
    set_frame(11'd1, 11'd1, 1'b0);
    send_pixel('1);
    send_pixel(16'h1234);
    settle();

    // 3x3 with edge extremes, a bright cross around a mid centre, then a
    // flush row whose values must be ignored
    set_frame(11'd3, 11'd3, 1'b0);
    seq = '{16'h0000, 16'hFFFF, 16'h0001,
            16'hFFFF, 16'h8000, 16'hFFFF,
            16'h7FFF, 16'hFFFF, 16'h0000,
            16'hFFFF, 16'h5555, 16'hAAAA};
    foreach (seq[i]) send_pixel(seq[i]);
    settle();

    // zero width and height both act as 1
    set_frame(11'd0, 11'd0, 1'b0);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    settle();

    // 2x2: every pixel sees exactly two in-frame neighbours
    set_frame(11'd2, 11'd2, 1'b0);
    seq = '{16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF, 16'h0F0F, 16'hF0F0};
    foreach (seq[i]) send_pixel(seq[i]);
    settle();
    settings = 4;

    // --- random -----------------------------------------------------------
    // Mostly complete frames (often several back to back, so the counters
    // wrap), some cut short before a reconfigure, and a handful of extreme
    // sizes spread across the idling regimes.
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 52;
      end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (big_done < 4 && random_items >= big_done * 160 + 40) begin
        case (big_done)
          0: begin wr = 1024; hr = 1;    end  // widest row
          1: begin wr = 1;    hr = 1024; end  // tallest column
          2: begin wr = 2047; hr = 0;    end  // clamps to 1024 x 1
          default: begin wr = 0; hr = 2047; end  // clamps to 1 x 1024
        endcase
        set_frame(CFG_BITS'(wr), CFG_BITS'(hr), 1'b0);
        // only the start of the frame; the next setting restarts it
        send_run(BIG_RUN, texture_t'($urandom_range(TEX_TIES, TEX_NOISE)));
        random_items += BIG_RUN;
        big_done++;
      end else begin
        wr = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        hr = $urandom_range(1, 8);
        set_frame(CFG_BITS'(wr), CFG_BITS'(hr), $urandom_range(0, 3) == 0);
        n_items = frame_items(wr, hr);
        repeat ($urandom_range(1, 3)) begin
          send_run(n_items, texture_t'($urandom_range(TEX_TIES, TEX_NOISE)));
          random_items += n_items;
        end
        // broken frame: stop part way, next phase reconfigures mid-frame
        if ($urandom_range(0, 3) == 0) begin
          n_items = $urandom_range(1, n_items - 1);
          send_run(n_items, TEX_NOISE);
          random_items += n_items;
        end
      end
      settle();
      settings++;
    end

    $display("Run covered %0d pixel transfers over %0d frame settings: small frames",
             pixels_sent, settings);
    $display("plus the starts of 1024-limit frames; %0d results compared, %0d frames closed.",
             checked_count, frame_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
